FILE: sv/jsu_pkg.sv
// shared types, character constants and decode functions for the json string unescaper
package jsu_pkg;

    // field widths
    localparam int CP_W    = 21;
    localparam int HEX_W   = 16;
    localparam int CNT_W   = 3;
    localparam int TDATA_W = 24;

    // hex run counter: start value, and the value held when the fourth digit is due
    localparam logic [CNT_W-1:0] HEX_RUN_START = 3'd1;
    localparam logic [CNT_W-1:0] HEX_RUN_LAST  = 3'd4;

    // character codes
    localparam logic [CP_W-1:0] CP_QUOTE  = 21'h22;
    localparam logic [CP_W-1:0] CP_BSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CP_DIG_0  = 21'h30;
    localparam logic [CP_W-1:0] CP_DIG_9  = 21'h39;
    localparam logic [CP_W-1:0] CP_LC_A   = 21'h61;
    localparam logic [CP_W-1:0] CP_LC_F   = 21'h66;
    localparam logic [CP_W-1:0] CP_UC_A   = 21'h41;
    localparam logic [CP_W-1:0] CP_UC_F   = 21'h46;
    localparam logic [CP_W-1:0] CP_LC_B   = 21'h62;
    localparam logic [CP_W-1:0] CP_UC_B   = 21'h42;
    localparam logic [CP_W-1:0] CP_UC_FF  = 21'h46;
    localparam logic [CP_W-1:0] CP_LC_N   = 21'h6E;
    localparam logic [CP_W-1:0] CP_UC_N   = 21'h4E;
    localparam logic [CP_W-1:0] CP_LC_R   = 21'h72;
    localparam logic [CP_W-1:0] CP_UC_R   = 21'h52;
    localparam logic [CP_W-1:0] CP_LC_T   = 21'h74;
    localparam logic [CP_W-1:0] CP_UC_T   = 21'h54;
    localparam logic [CP_W-1:0] CP_LC_U   = 21'h75;
    localparam logic [CP_W-1:0] CP_UC_U   = 21'h55;

    // decoded control characters
    localparam logic [CP_W-1:0] CP_BS  = 21'h08;
    localparam logic [CP_W-1:0] CP_FF  = 21'h0C;
    localparam logic [CP_W-1:0] CP_LF  = 21'h0A;
    localparam logic [CP_W-1:0] CP_CR  = 21'h0D;
    localparam logic [CP_W-1:0] CP_TAB = 21'h09;

    localparam logic [3:0] HEX_TEN = 4'hA;

    // one input character with its end marker
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            end_of_string;
    } t_item;

    // result of decoding the character after a backslash
    typedef struct packed {
        logic            start_hex;
        logic            valid;
        logic [CP_W-1:0] ch;
    } t_esc;

    // hex digit value, anything else counts as zero
    function automatic logic [3:0] hex_value(input logic [CP_W-1:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c >= CP_DIG_0 && c <= CP_DIG_9) begin
            v = 4'(c - CP_DIG_0);
        end else if (c >= CP_LC_A && c <= CP_LC_F) begin
            v = 4'(c - CP_LC_A) + HEX_TEN;
        end else if (c >= CP_UC_A && c <= CP_UC_F) begin
            v = 4'(c - CP_UC_A) + HEX_TEN;
        end
        return v;
    endfunction

    // escape letter map, case-insensitive
    function automatic t_esc escape_map(input logic [CP_W-1:0] c);
        t_esc e;
        e.start_hex = 1'b0;
        e.valid     = 1'b1;
        e.ch        = c;
        unique case (c)
            CP_LC_B, CP_UC_B: e.ch = CP_BS;
            CP_LC_F, CP_UC_FF: e.ch = CP_FF;
            CP_LC_N, CP_UC_N: e.ch = CP_LF;
            CP_LC_R, CP_UC_R: e.ch = CP_CR;
            CP_LC_T, CP_UC_T: e.ch = CP_TAB;
            CP_LC_U, CP_UC_U: begin
                e.start_hex = 1'b1;
                e.valid     = 1'b0;
                e.ch        = '0;
            end
            default: e.ch = c;
        endcase
        return e;
    endfunction

endpackage

FILE: sv/json_string_unescaper_core.sv
// json string unescaper top level: input register, decoder and result register
// path: each character passes the input register and then the result register
// throughput: one character per cycle while the result output is not stalled
// reset: synchronous active low; clears both stage valid flags and the string state
// one result per character; tuser flags whether it carries a decoded character
module json_string_unescaper_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [jsu_pkg::TDATA_W-1:0]   i_s_tdata,  // [20:0] code_point, rest zero
    input  logic                          i_s_tlast,  // end_of_string
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [jsu_pkg::TDATA_W-1:0]   o_m_tdata,  // [20:0] decoded_char, rest zero
    output logic                          o_m_tuser,  // [0] char_valid
    output logic                          o_m_tlast   // string_done
);
    import jsu_pkg::*;

    t_item           in_item;
    t_item           held_item;
    logic            held_valid;
    logic            take;
    logic [CP_W-1:0] dec_char;

    assign in_item.code_point    = i_s_tdata[CP_W-1:0];
    assign in_item.end_of_string = i_s_tlast;

    // input register
    jsu_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (take),
        .o_item  (held_item)
    );

    // decode and result register
    jsu_decoder u_decoder (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (held_valid),
        .i_item         (held_item),
        .o_take         (take),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_char_valid   (o_m_tuser),
        .o_decoded_char (dec_char),
        .o_string_done  (o_m_tlast)
    );

    assign o_m_tdata = {{(TDATA_W-CP_W){1'b0}}, dec_char};

endmodule

FILE: sv/jsu_in_reg.sv
// input register stage that holds one accepted character
module jsu_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  jsu_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_take,
    output jsu_pkg::t_item o_item
);
    import jsu_pkg::*;

    logic  r_valid;
    t_item r_item;

    // room when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: sv/jsu_decoder.sv
// string state, one-step decode and result register
module jsu_decoder (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  jsu_pkg::t_item           i_item,
    output logic                     o_take,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_char_valid,
    output logic [jsu_pkg::CP_W-1:0] o_decoded_char,
    output logic                     o_string_done
);
    import jsu_pkg::*;

    logic             r_inside;
    logic             r_escape;
    logic [CNT_W-1:0] r_hex_cnt;
    logic [HEX_W-1:0] r_hex_acc;
    logic             n_inside;
    logic             n_escape;
    logic [CNT_W-1:0] n_hex_cnt;
    logic [HEX_W-1:0] n_hex_acc;

    logic             r_out_valid;
    logic             r_char_valid;
    logic [CP_W-1:0]  r_decoded_char;
    logic             r_string_done;

    logic             res_valid;
    logic [CP_W-1:0]  res_char;
    logic [CP_W-1:0]  c;
    t_esc             esc;

    assign c      = i_item.code_point;
    assign esc    = escape_map(c);
    assign o_take = i_valid && (!r_out_valid || i_ready);

    // next state and result for the held character
    always_comb begin
        n_inside  = r_inside;
        n_escape  = r_escape;
        n_hex_cnt = r_hex_cnt;
        n_hex_acc = r_hex_acc;
        res_valid = 1'b0;
        res_char  = '0;
        priority if (!r_inside) begin
            if (c == CP_QUOTE) begin
                n_inside = 1'b1;
            end else begin
                res_valid = 1'b1;
                res_char  = c;
            end
        end else if (r_hex_cnt != '0) begin
            n_hex_acc = {r_hex_acc[HEX_W-5:0], hex_value(c)};
            if (r_hex_cnt == HEX_RUN_LAST) begin
                res_valid = 1'b1;
                res_char  = {{(CP_W-HEX_W){1'b0}}, n_hex_acc};
                n_hex_cnt = '0;
            end else begin
                n_hex_cnt = r_hex_cnt + 3'd1;
            end
        end else if (r_escape) begin
            n_escape  = 1'b0;
            res_valid = esc.valid;
            res_char  = esc.ch;
            if (esc.start_hex) begin
                n_hex_cnt = HEX_RUN_START;
                n_hex_acc = '0;
            end
        end else if (c == CP_QUOTE) begin
            n_inside = 1'b0;
        end else if (c == CP_BSLASH) begin
            n_escape = 1'b1;
        end else begin
            res_valid = 1'b1;
            res_char  = c;
        end
        // end of token drops all state
        if (i_item.end_of_string) begin
            n_inside  = 1'b0;
            n_escape  = 1'b0;
            n_hex_cnt = '0;
            n_hex_acc = '0;
        end
    end

    // string state, advanced once per taken character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside  <= 1'b0;
            r_escape  <= 1'b0;
            r_hex_cnt <= '0;
            r_hex_acc <= '0;
        end else if (o_take) begin
            r_inside  <= n_inside;
            r_escape  <= n_escape;
            r_hex_cnt <= n_hex_cnt;
            r_hex_acc <= n_hex_acc;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_char_valid   <= res_valid;
            r_decoded_char <= res_char;
            r_string_done  <= i_item.end_of_string;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_char_valid   = r_char_valid;
    assign o_decoded_char = r_decoded_char;
    assign o_string_done  = r_string_done;

endmodule

FILE: sv/jsu_checker.sv
// port-level checks for the json string unescaper, bound to the top level
module jsu_port_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic [jsu_pkg::TDATA_W-1:0] i_s_tdata,
    input logic                        i_s_tlast,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [jsu_pkg::TDATA_W-1:0] o_m_tdata,
    input logic                        o_m_tuser,
    input logic                        o_m_tlast
);
    import jsu_pkg::*;

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser)
            && $stable(o_m_tlast))
        else $error("result payload changed while stalled");

    // no decoded character means zero data
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("data present without decoded character");

    // pad bits above the code point stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[TDATA_W-1:CP_W] == '0)
        else $error("tdata pad bits set");

    // nothing is offered in the cycle after reset is released
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result offered right after reset");

endmodule

bind json_string_unescaper_core jsu_port_checker u_jsu_port_checker (.*);
